/* rtl/bba_pkg.sv */
// Shared types, codes and sizing constants for the buddy block allocator.
// No dependencies; every other rtl file but bba_ram refers to this package by scoped name.
`timescale 1ns / 1ps
`default_nettype none

package bba_pkg;

    // Default size of the managed memory, log2 of the unit count
    localparam int LOG_UNITS_DEF = 10;

    // Fixed field widths of the item and result ports
    localparam int SIZE_W  = 11;
    localparam int START_W = 10;
    localparam int ORDER_W = 4;
    localparam int STAT_W  = 2;

    // Order counters hold 0 .. LOG_UNITS+1 for LOG_UNITS up to 30
    localparam int ORD_W = 5;

    // Free map rows: 32 node bits per memory word
    localparam int ROW_BITS = 5;
    localparam int ROW_W    = 1 << ROW_BITS;

    // Command codes
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_NO_SPACE  = 2'd1;
    localparam logic [STAT_W-1:0] ST_ZERO_SIZE = 2'd2;

    // Controller states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_RD,
        S_WR
    } t_state;

    // Read-modify-write operation on one node bit
    typedef enum logic [1:0] {
        OP_TAKE,
        OP_SPLIT,
        OP_MERGE,
        OP_SET
    } t_op;

    // Controller to datapath commands
    typedef struct packed {
        logic              clr_step;
        logic              alloc_load;
        logic              free_load;
        logic              scan_step;
        logic              hit_take;
        logic              rmw_wr;
        logic              emit;
        logic              emit_grant;
        logic [STAT_W-1:0] status;
        t_op               op;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic clr_last;
        logic zero_size;
        logic too_big;
        logic free_bad;
        logic free_top;
        logic scan_hit;
        logic scan_fail;
        logic bit_set;
        logic at_want;
        logic next_top;
    } t_dp_sts;

endpackage

`default_nettype wire

/* rtl/bba_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module bba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write, then register the read word
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* rtl/bba_ctrl.sv */
// Controller of the buddy block allocator: sequences clear, scan, split and merge.
// Depends on bba_pkg; drives the datapath only through bba_pkg::t_dp_cmd.
`timescale 1ns / 1ps
`default_nettype none

module bba_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic             i_command,
    input  wire bba_pkg::t_dp_sts i_sts,
    output bba_pkg::t_dp_cmd      o_cmd,
    output logic                  o_busy
);

    bba_pkg::t_state r_state, n_state;
    bba_pkg::t_op    r_op, n_op;

    // State and operation registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bba_pkg::S_CLEAR;
            r_op    <= bba_pkg::OP_SET;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
        end
    end

    // Next state and commands
    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        o_cmd    = '0;
        o_cmd.op = r_op;
        o_busy   = (r_state != bba_pkg::S_IDLE);
        unique case (r_state)
            bba_pkg::S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = bba_pkg::S_IDLE;
                end
            end
            bba_pkg::S_IDLE: begin
                if (i_start) begin
                    if (i_command == bba_pkg::CMD_ALLOC) begin
                        if (i_sts.zero_size) begin
                            o_cmd.emit   = 1'b1;
                            o_cmd.status = bba_pkg::ST_ZERO_SIZE;
                        end else if (i_sts.too_big) begin
                            o_cmd.emit   = 1'b1;
                            o_cmd.status = bba_pkg::ST_NO_SPACE;
                        end else begin
                            o_cmd.alloc_load = 1'b1;
                            n_state          = bba_pkg::S_SCAN;
                        end
                    end else begin
                        if (i_sts.free_bad) begin
                            // drop the free, still answer it
                            o_cmd.emit   = 1'b1;
                            o_cmd.status = bba_pkg::ST_OK;
                        end else begin
                            o_cmd.free_load = 1'b1;
                            n_op    = i_sts.free_top ? bba_pkg::OP_SET : bba_pkg::OP_MERGE;
                            n_state = bba_pkg::S_RD;
                        end
                    end
                end
            end
            bba_pkg::S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_hit) begin
                    o_cmd.hit_take = 1'b1;
                    n_op           = bba_pkg::OP_TAKE;
                    n_state        = bba_pkg::S_RD;
                end else if (i_sts.scan_fail) begin
                    o_cmd.emit   = 1'b1;
                    o_cmd.status = bba_pkg::ST_NO_SPACE;
                    n_state      = bba_pkg::S_IDLE;
                end
            end
            bba_pkg::S_RD: begin
                n_state = bba_pkg::S_WR;
            end
            bba_pkg::S_WR: begin
                o_cmd.rmw_wr = 1'b1;
                unique case (r_op) inside
                    bba_pkg::OP_TAKE, bba_pkg::OP_SPLIT: begin
                        if (i_sts.at_want) begin
                            o_cmd.emit       = 1'b1;
                            o_cmd.emit_grant = 1'b1;
                            o_cmd.status     = bba_pkg::ST_OK;
                            n_state          = bba_pkg::S_IDLE;
                        end else begin
                            n_op    = bba_pkg::OP_SPLIT;
                            n_state = bba_pkg::S_RD;
                        end
                    end
                    bba_pkg::OP_MERGE: begin
                        n_op    = (i_sts.bit_set && !i_sts.next_top) ?
                                  bba_pkg::OP_MERGE : bba_pkg::OP_SET;
                        n_state = bba_pkg::S_RD;
                    end
                    default: begin
                        o_cmd.emit   = 1'b1;
                        o_cmd.status = bba_pkg::ST_OK;
                        n_state      = bba_pkg::S_IDLE;
                    end
                endcase
            end
            default: begin
                n_state = bba_pkg::S_CLEAR;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/bba_dp.sv */
// Datapath of the buddy block allocator: free map RAM, scan pointer, node walker.
// Depends on bba_pkg and bba_ram; controlled by bba_ctrl through t_dp_cmd.
`timescale 1ns / 1ps
`default_nettype none

module bba_dp #(
    parameter int LOG_UNITS = bba_pkg::LOG_UNITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire bba_pkg::t_dp_cmd             i_cmd,
    output bba_pkg::t_dp_sts                  o_sts,
    input  wire logic [bba_pkg::SIZE_W-1:0]   i_request_size,
    input  wire logic [bba_pkg::START_W-1:0]  i_block_start,
    input  wire logic [bba_pkg::ORDER_W-1:0]  i_block_order,
    output logic                              o_valid,
    output logic      [bba_pkg::START_W-1:0]  o_granted_start,
    output logic      [bba_pkg::ORDER_W-1:0]  o_granted_order,
    output logic      [bba_pkg::STAT_W-1:0]   o_status
);

    localparam int NODE_W = LOG_UNITS + 1;
    localparam int BW     = bba_pkg::ROW_BITS;
    localparam int RW     = bba_pkg::ROW_W;
    localparam int OW     = bba_pkg::ORD_W;
    localparam int SW     = bba_pkg::START_W;
    localparam int ROW_AW = (NODE_W > BW) ? NODE_W - BW : 1;
    localparam int DEPTH  = 1 << ROW_AW;
    localparam int SL_W   = ((LOG_UNITS > SW) ? LOG_UNITS : SW) + 1;
    localparam logic [OW-1:0]     TOP_ORD    = OW'(LOG_UNITS);
    localparam logic [RW-1:0]     ROOT_ROW   = RW'(2);
    localparam logic [SW-1:0]     START_MASK = (LOG_UNITS >= SW) ? '1 :
                                               SW'((1 << LOG_UNITS) - 1);
    localparam logic [ROW_AW-1:0] LAST_CROW  = ROW_AW'(DEPTH - 1);

    // Order of the smallest power of two at or above the size
    function automatic logic [OW-1:0] f_want(input logic [bba_pkg::SIZE_W-1:0] size);
        logic [bba_pkg::SIZE_W-1:0] m;
        logic [OW-1:0]              w;
        m = size - bba_pkg::SIZE_W'(1);
        w = '0;
        for (int j = 0; j < bba_pkg::SIZE_W; j++) begin
            if (m[j]) w = OW'(j + 1);
        end
        if (size == '0) w = '0;
        return w;
    endfunction

    // Position of the lowest set bit
    function automatic logic [BW-1:0] f_low(input logic [RW-1:0] v);
        logic [BW-1:0] p;
        p = '0;
        for (int j = RW - 1; j >= 0; j--) begin
            if (v[j]) p = BW'(j);
        end
        return p;
    endfunction

    // First and last map row that holds nodes of an order
    function automatic logic [ROW_AW-1:0] f_first_row(input logic [OW-1:0] o);
        logic [NODE_W:0] b;
        b = (NODE_W + 1)'(1) << (TOP_ORD - o);
        return ROW_AW'(b >> BW);
    endfunction

    function automatic logic [ROW_AW-1:0] f_last_row(input logic [OW-1:0] o);
        logic [NODE_W:0] b;
        b = ((NODE_W + 1)'(1) << (TOP_ORD - o + OW'(1))) - (NODE_W + 1)'(1);
        return ROW_AW'(b >> BW);
    endfunction

    logic [OW-1:0]     r_want, n_want;
    logic [OW-1:0]     r_ord, n_ord;
    logic [NODE_W-1:0] r_node, n_node;
    logic [ROW_AW-1:0] r_irow, n_irow;
    logic [OW-1:0]     r_iord, n_iord;
    logic              r_idone, n_idone;
    logic              r_tvalid, n_tvalid;
    logic [OW-1:0]     r_tord, n_tord;
    logic [ROW_AW-1:0] r_trow, n_trow;
    logic [ROW_AW-1:0] r_crow, n_crow;
    logic              r_valid, n_valid;
    logic [SW-1:0]     r_start, n_start;
    logic [bba_pkg::ORDER_W-1:0] r_order, n_order;
    logic [bba_pkg::STAT_W-1:0]  r_status, n_status;

    logic [RW-1:0]        rd_data;
    logic [RW-1:0]        wr_data;
    logic                 we;
    logic [ROW_AW-1:0]    waddr;
    logic [ROW_AW-1:0]    raddr;
    logic [OW-1:0]        c_want;
    logic [OW-1:0]        scan_sh;
    logic [RW-1:0]        scan_mask;
    logic [RW-1:0]        scan_hits;
    logic [NODE_W-1:0]    tgt;
    logic [ROW_AW-1:0]    tgt_row;
    logic [BW-1:0]        tgt_bit;
    logic                 set_val;
    logic [LOG_UNITS-1:0] start_l;
    logic [SL_W-1:0]      grant_sh;

    bba_ram #(
        .WIDTH (RW),
        .DEPTH (DEPTH)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wr_data),
        .i_raddr (raddr),
        .o_rdata (rd_data)
    );

    // Request decode
    assign c_want  = f_want(i_request_size);
    assign start_l = LOG_UNITS'(i_block_start);

    // Mask the returned scan row to the nodes of the tagged order
    always_comb begin
        scan_sh = TOP_ORD - r_tord;
        if (scan_sh >= OW'(BW)) begin
            scan_mask = '1;
        end else begin
            for (int j = 0; j < RW; j++) begin
                scan_mask[j] = ((BW'(j) >> scan_sh) == BW'(1));
            end
        end
        scan_hits = rd_data & scan_mask;
    end

    // Node under read-modify-write: buddy on merge, upper half on split
    always_comb begin
        unique case (i_cmd.op)
            bba_pkg::OP_MERGE: tgt = r_node ^ NODE_W'(1);
            bba_pkg::OP_SPLIT: tgt = r_node | NODE_W'(1);
            default:           tgt = r_node;
        endcase
        tgt_row = ROW_AW'(tgt >> BW);
        tgt_bit = BW'(tgt);
    end

    // Status to the controller
    always_comb begin
        o_sts.clr_last  = (r_crow == LAST_CROW);
        o_sts.zero_size = (i_request_size == '0);
        o_sts.too_big   = (c_want > TOP_ORD);
        o_sts.free_bad  = (OW'(i_block_order) > TOP_ORD);
        o_sts.free_top  = (OW'(i_block_order) == TOP_ORD);
        o_sts.scan_hit  = r_tvalid && (scan_hits != '0);
        o_sts.scan_fail = r_idone && !r_tvalid;
        o_sts.bit_set   = rd_data[tgt_bit];
        o_sts.at_want   = (r_ord == r_want);
        o_sts.next_top  = ((r_ord + OW'(1)) == TOP_ORD);
    end

    // Map port control
    always_comb begin
        raddr   = i_cmd.scan_step ? r_irow : tgt_row;
        set_val = (i_cmd.op == bba_pkg::OP_SPLIT) || (i_cmd.op == bba_pkg::OP_SET);
        we      = 1'b0;
        waddr   = tgt_row;
        wr_data = rd_data;
        if (i_cmd.clr_step) begin
            we      = 1'b1;
            waddr   = r_crow;
            wr_data = (r_crow == '0) ? ROOT_ROW : '0;
        end else if (i_cmd.rmw_wr) begin
            we               = (i_cmd.op != bba_pkg::OP_MERGE) || rd_data[tgt_bit];
            wr_data[tgt_bit] = set_val;
        end
    end

    // Next values of the walker, scan pointer and result
    always_comb begin
        n_want   = r_want;
        n_ord    = r_ord;
        n_node   = r_node;
        n_irow   = r_irow;
        n_iord   = r_iord;
        n_idone  = r_idone;
        n_tvalid = r_tvalid;
        n_tord   = r_tord;
        n_trow   = r_trow;
        n_crow   = r_crow;
        n_valid  = 1'b0;
        n_start  = r_start;
        n_order  = r_order;
        n_status = r_status;
        grant_sh = SL_W'(r_node) << r_want;

        // advance the clearing sweep
        if (i_cmd.clr_step) begin
            n_crow = r_crow + ROW_AW'(1);
        end

        // start a scan at the wanted order
        if (i_cmd.alloc_load) begin
            n_want   = c_want;
            n_iord   = c_want;
            n_irow   = f_first_row(c_want);
            n_idone  = 1'b0;
            n_tvalid = 1'b0;
        end

        // issue one row a cycle, tag it for the check in the next cycle
        if (i_cmd.scan_step) begin
            if (!r_idone) begin
                n_tvalid = 1'b1;
                n_tord   = r_iord;
                n_trow   = r_irow;
                if (r_irow == f_last_row(r_iord)) begin
                    n_iord  = r_iord + OW'(1);
                    n_irow  = f_first_row(r_iord + OW'(1));
                    n_idone = (r_iord == TOP_ORD);
                end else begin
                    n_irow = r_irow + ROW_AW'(1);
                end
            end else begin
                n_tvalid = 1'b0;
            end
        end

        // latch the lowest free node found
        if (i_cmd.hit_take) begin
            n_node = NODE_W'({r_trow, f_low(scan_hits)});
            n_ord  = r_tord;
        end

        // node of the freed block
        if (i_cmd.free_load) begin
            n_node = NODE_W'({1'b1, start_l} >> i_block_order);
            n_ord  = OW'(i_block_order);
        end

        // walk down on split, up on merge
        if (i_cmd.rmw_wr) begin
            case (i_cmd.op)
                bba_pkg::OP_TAKE, bba_pkg::OP_SPLIT: begin
                    if (r_ord != r_want) begin
                        n_node = r_node << 1;
                        n_ord  = r_ord - OW'(1);
                    end
                end
                bba_pkg::OP_MERGE: begin
                    if (rd_data[tgt_bit]) begin
                        n_node = r_node >> 1;
                        n_ord  = r_ord + OW'(1);
                    end
                end
                default: begin
                end
            endcase
        end

        // result
        if (i_cmd.emit) begin
            n_valid  = 1'b1;
            n_status = i_cmd.status;
            if (i_cmd.emit_grant) begin
                n_start = SW'(grant_sh) & START_MASK;
                n_order = bba_pkg::ORDER_W'(r_want);
            end else begin
                n_start = '0;
                n_order = '0;
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crow   <= '0;
            r_valid  <= 1'b0;
            r_tvalid <= 1'b0;
            r_idone  <= 1'b0;
        end else begin
            r_crow   <= n_crow;
            r_valid  <= n_valid;
            r_tvalid <= n_tvalid;
            r_idone  <= n_idone;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_want   <= n_want;
        r_ord    <= n_ord;
        r_node   <= n_node;
        r_irow   <= n_irow;
        r_iord   <= n_iord;
        r_tord   <= n_tord;
        r_trow   <= n_trow;
        r_start  <= n_start;
        r_order  <= n_order;
        r_status <= n_status;
    end

    assign o_valid         = r_valid;
    assign o_granted_start = r_start;
    assign o_granted_order = r_order;
    assign o_status        = r_status;

endmodule

`default_nettype wire

/* rtl/buddy_block_allocator_core.sv */
// Top level of the buddy block allocator: controller plus datapath.
// Depends on bba_pkg, bba_ctrl, bba_dp (which holds bba_ram).
//
//  Channel  | Handshake                 | Ports
//  ---------+---------------------------+-------------------------------------------------
//  item in  | start high, busy low      | i_command, i_request_size, i_block_start,
//           |                           | i_block_order
//  result   | o_valid, one cycle only   | o_granted_start, o_granted_order, o_status
//
// Sequencing: a rejected request or a dropped free answers in the cycle after start
// with busy staying low. An allocate scans the free map one 32-node RAM row per
// cycle, order by order (68 rows over all orders at the default), then does one
// read and one write of the map per bit update (take plus one per split); a free
// does one read and write per buddy checked plus one to mark the merged block,
// all through the single map RAM port pair. Reset starts a clearing pass over
// every map row with busy high throughout. Results cannot be stalled; each is
// shown for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none

module buddy_block_allocator_core #(
    parameter int LOG_UNITS = bba_pkg::LOG_UNITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic                         i_command,
    input  wire logic [bba_pkg::SIZE_W-1:0]   i_request_size,
    input  wire logic [bba_pkg::START_W-1:0]  i_block_start,
    input  wire logic [bba_pkg::ORDER_W-1:0]  i_block_order,
    output logic                              o_valid,
    output logic      [bba_pkg::START_W-1:0]  o_granted_start,
    output logic      [bba_pkg::ORDER_W-1:0]  o_granted_order,
    output logic      [bba_pkg::STAT_W-1:0]   o_status
);

    bba_pkg::t_dp_cmd cmd;
    bba_pkg::t_dp_sts sts;

    bba_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_command (i_command),
        .i_sts     (sts),
        .o_cmd     (cmd),
        .o_busy    (busy)
    );

    bba_dp #(
        .LOG_UNITS (LOG_UNITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_request_size  (i_request_size),
        .i_block_start   (i_block_start),
        .i_block_order   (i_block_order),
        .o_valid         (o_valid),
        .o_granted_start (o_granted_start),
        .o_granted_order (o_granted_order),
        .o_status        (o_status)
    );

    // A failed or rejected request carries no grant
    a_err_no_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != bba_pkg::ST_OK) |->
            (o_granted_start == '0) && (o_granted_order == '0))
        else $error("error result carries a grant");

    // A zero-size allocate is rejected in the next cycle
    a_zero_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_command == bba_pkg::CMD_ALLOC) && (i_request_size == '0) |=>
            o_valid && (o_status == bba_pkg::ST_ZERO_SIZE))
        else $error("zero-size allocate not rejected");

    // Reset starts the clearing pass
    a_reset_busy: assert property (@(posedge i_clk)
        !i_rst_n |=> busy)
        else $error("not busy after reset");

endmodule

`default_nettype wire

/* verif/bba_checker.sv */
// Checker for the buddy block allocator: watches the item and result channels.
// Predicts each result from its own free map and compares; depends on bba_pkg.
`timescale 1ns / 1ps

module bba_checker #(
    parameter int LOG_UNITS = bba_pkg::LOG_UNITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    input  logic                            busy,
    input  logic                            i_command,
    input  logic [bba_pkg::SIZE_W-1:0]      i_request_size,
    input  logic [bba_pkg::START_W-1:0]     i_block_start,
    input  logic [bba_pkg::ORDER_W-1:0]     i_block_order,
    input  logic                            o_valid,
    input  logic [bba_pkg::START_W-1:0]     o_granted_start,
    input  logic [bba_pkg::ORDER_W-1:0]     o_granted_order,
    input  logic [bba_pkg::STAT_W-1:0]      o_status,
    output int                              fail_count,
    output int                              pending_grants
);

    localparam int NODES = (1 << (LOG_UNITS + 1)) - 1;

    typedef struct packed {
        logic [bba_pkg::START_W-1:0] start_unit;
        logic [bba_pkg::ORDER_W-1:0] order;
        logic [bba_pkg::STAT_W-1:0]  status;
    } t_grant;

    logic   free_bits [NODES];
    t_grant grant_q [$];

    function automatic int node_at(int k, int idx);
        return (1 << (LOG_UNITS - k)) + idx - 1;
    endfunction

    // Work out the answer to one item and update the free map
    function automatic t_grant serve_item(logic cmd, logic [bba_pkg::SIZE_W-1:0] size,
                                          logic [bba_pkg::START_W-1:0] bstart,
                                          logic [bba_pkg::ORDER_W-1:0] bord);
        t_grant g;
        int want, k, idx, t, buddy;
        bit found;
        g = '0;
        found = 0;
        idx = 0;
        k = 0;
        if (cmd == bba_pkg::CMD_ALLOC) begin
            if (size == 0) begin
                g.status = bba_pkg::ST_ZERO_SIZE;
                return g;
            end
            want = 0;
            while (want < 12 && (1 << want) < int'(size)) want++;
            if (want > LOG_UNITS) begin
                g.status = bba_pkg::ST_NO_SPACE;
                return g;
            end
            // Lowest-address free block of the smallest fitting order
            for (k = want; k <= LOG_UNITS && !found; k++) begin
                for (idx = 0; idx < (1 << (LOG_UNITS - k)); idx++) begin
                    if (free_bits[node_at(k, idx)]) begin
                        found = 1;
                        break;
                    end
                end
                if (found) break;
            end
            if (!found) begin
                g.status = bba_pkg::ST_NO_SPACE;
                return g;
            end
            free_bits[node_at(k, idx)] = 0;
            // Split down, freeing each upper half
            for (t = k; t > want; t--) begin
                idx = idx << 1;
                free_bits[node_at(t - 1, idx + 1)] = 1;
            end
            g.start_unit = bba_pkg::START_W'(idx << want);
            g.order = bba_pkg::ORDER_W'(want);
            g.status = bba_pkg::ST_OK;
        end else if (int'(bord) <= LOG_UNITS) begin
            k = int'(bord);
            idx = (int'(bstart) >> k) & ((1 << (LOG_UNITS - k)) - 1);
            // Merge with free buddies order by order
            while (k < LOG_UNITS) begin
                buddy = idx ^ 1;
                if (!free_bits[node_at(k, buddy)]) break;
                free_bits[node_at(k, buddy)] = 0;
                idx = idx >> 1;
                k++;
            end
            free_bits[node_at(k, idx)] = 1;
        end
        return g;
    endfunction

    assign pending_grants = grant_q.size();

    always @(posedge i_clk) begin
        t_grant want_g;
        int     errs;
        errs = 0;
        if (!i_rst_n) begin
            for (int n = 0; n < NODES; n++) free_bits[n] = 0;
            free_bits[0] = 1;
            grant_q.delete();
            fail_count <= 0;
        end else begin
            // Compare a shown result with the oldest expectation
            if (o_valid) begin
                if (grant_q.size() == 0) begin
                    $error("result with no item outstanding");
                    errs++;
                end else begin
                    want_g = grant_q.pop_front();
                    if (o_granted_start !== want_g.start_unit) begin
                        $error("granted_start exp %0d got %0d", want_g.start_unit,
                               o_granted_start);
                        errs++;
                    end
                    if (o_granted_order !== want_g.order) begin
                        $error("granted_order exp %0d got %0d", want_g.order,
                               o_granted_order);
                        errs++;
                    end
                    if (o_status !== want_g.status) begin
                        $error("status exp %0d got %0d", want_g.status, o_status);
                        errs++;
                    end
                end
            end
            // Predict each accepted item
            if (start && !busy)
                grant_q.insert(grant_q.size(), serve_item(i_command, i_request_size,
                                                          i_block_start, i_block_order));
            fail_count <= fail_count + errs;
        end
    end

endmodule

/* verif/tb.sv */
// Testbench top for the buddy block allocator: clock, reset, stimulus, verdict.
// Depends on bba_pkg, buddy_block_allocator_core and bba_checker.
`timescale 1ns / 1ps

module tb;

    localparam int CYCLE_LIMIT = 600000;
    localparam int RANDOM_ITEMS = 1030;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        start;
    logic                        busy;
    logic                        i_command;
    logic [bba_pkg::SIZE_W-1:0]  i_request_size;
    logic [bba_pkg::START_W-1:0] i_block_start;
    logic [bba_pkg::ORDER_W-1:0] i_block_order;
    logic                        o_valid;
    logic [bba_pkg::START_W-1:0] o_granted_start;
    logic [bba_pkg::ORDER_W-1:0] o_granted_order;
    logic [bba_pkg::STAT_W-1:0]  o_status;
    int                          fail_count;
    int                          pending_grants;

    typedef struct packed {
        logic [bba_pkg::START_W-1:0] start_unit;
        logic [bba_pkg::ORDER_W-1:0] order;
    } t_block;

    t_block live_q [$];
    logic   sent_cmd_q [$];
    int     items_sent;
    int     grants_ok = 0;
    int     cycles = 0;
    int     burst_left;

    buddy_block_allocator_core u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_command(i_command), .i_request_size(i_request_size),
        .i_block_start(i_block_start), .i_block_order(i_block_order),
        .o_valid(o_valid), .o_granted_start(o_granted_start),
        .o_granted_order(o_granted_order), .o_status(o_status)
    );

    bba_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_command(i_command), .i_request_size(i_request_size),
        .i_block_start(i_block_start), .i_block_order(i_block_order),
        .o_valid(o_valid), .o_granted_start(o_granted_start),
        .o_granted_order(o_granted_order), .o_status(o_status),
        .fail_count(fail_count), .pending_grants(pending_grants)
    );

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    // Track granted blocks so later frees can hand them back
    always @(posedge i_clk) begin
        t_block b;
        if (i_rst_n && o_valid && sent_cmd_q.size() > 0) begin
            if (sent_cmd_q.pop_front() == bba_pkg::CMD_ALLOC &&
                o_status == bba_pkg::ST_OK) begin
                b.start_unit = o_granted_start;
                b.order = o_granted_order;
                live_q.insert(live_q.size(), b);
                grants_ok++;
            end
        end
    end

    // Hard stop on a hang
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Present one item after an optional gap, hold until accepted
    task automatic send_item(logic cmd, int size, int bstart, int bord);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
        burst_left--;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_command <= cmd;
        i_request_size <= bba_pkg::SIZE_W'(size);
        i_block_start <= bba_pkg::START_W'(bstart);
        i_block_order <= bba_pkg::ORDER_W'(bord);
        do @(posedge i_clk); while (busy);
        sent_cmd_q.insert(sent_cmd_q.size(), cmd);
        items_sent++;
    endtask

    // Allocate size: mostly small, some large, a few oversize or zero
    function automatic int pick_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3) return 0;
        if (r < 6) return $urandom_range(1025, 2047);
        if (r < 14) return $urandom_range(65, 1024);
        return $urandom_range(1, 64);
    endfunction

    initial begin
        int idx;
        t_block b;
        items_sent = 0;
        burst_left = 0;
        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_command <= bba_pkg::CMD_ALLOC;
        i_request_size <= '0;
        i_block_start <= '0;
        i_block_order <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: zero size, whole memory, no space, oversize, odd frees
        send_item(bba_pkg::CMD_ALLOC, 0, 0, 0);
        send_item(bba_pkg::CMD_ALLOC, 1024, 0, 0);
        send_item(bba_pkg::CMD_ALLOC, 1, 0, 0);
        send_item(bba_pkg::CMD_FREE, 0, 0, 10);
        send_item(bba_pkg::CMD_ALLOC, 2047, 0, 0);
        send_item(bba_pkg::CMD_ALLOC, 1025, 0, 0);
        send_item(bba_pkg::CMD_ALLOC, 1, 0, 0);
        send_item(bba_pkg::CMD_ALLOC, 2, 0, 0);
        send_item(bba_pkg::CMD_ALLOC, 3, 0, 0);
        send_item(bba_pkg::CMD_ALLOC, 512, 0, 0);
        send_item(bba_pkg::CMD_ALLOC, 513, 0, 0);
        send_item(bba_pkg::CMD_FREE, 2047, 1023, 15);
        send_item(bba_pkg::CMD_FREE, 0, 512, 9);
        send_item(bba_pkg::CMD_FREE, 0, 4, 2);
        send_item(bba_pkg::CMD_FREE, 0, 3, 1);
        send_item(bba_pkg::CMD_FREE, 0, 0, 0);
        send_item(bba_pkg::CMD_FREE, 0, 1, 0);
        send_item(bba_pkg::CMD_ALLOC, 1024, 0, 0);
        send_item(bba_pkg::CMD_FREE, 0, 1023, 3);
        send_item(bba_pkg::CMD_FREE, 0, 0, 10);
        send_item(bba_pkg::CMD_FREE, 0, 0, 10);
        send_item(bba_pkg::CMD_ALLOC, 1024, 0, 0);
        send_item(bba_pkg::CMD_FREE, 0, 0, 10);

        // Drain so the live list matches the grants seen
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_grants != 0) @(posedge i_clk);
        live_q.delete();

        // Random: mostly alloc/free of real blocks, some noise frees
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 2) begin
                start <= 1'b0;
                @(posedge i_clk);
                while (pending_grants != 0) @(posedge i_clk);
            end
            if ($urandom_range(0, 19) == 0) begin
                send_item(bba_pkg::CMD_FREE, $urandom_range(0, 2047),
                          $urandom_range(0, 1023), $urandom_range(0, 15));
            end else if (live_q.size() > 0 &&
                         ($urandom_range(0, 1) == 0 || live_q.size() > 40)) begin
                idx = $urandom_range(0, live_q.size() - 1);
                b = live_q[idx];
                live_q.delete(idx);
                send_item(bba_pkg::CMD_FREE, $urandom_range(0, 2047), b.start_unit,
                          b.order);
            end else begin
                send_item(bba_pkg::CMD_ALLOC, pick_size(), $urandom_range(0, 1023),
                          $urandom_range(0, 15));
            end
        end
        start <= 1'b0;

        @(posedge i_clk);
        while (pending_grants != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);

        $display("Ran %0d items (alloc, free, zero, oversize, stray frees); %0d grants.",
                 items_sent, grants_ok);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
